[rtl/othp_pkg.sv]
// ----------------------------------------------------------------------------
// othp_pkg: shared types and constants of the offset-table header parser
// Byte event record, result record, parser phases and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package othp_pkg;

   // payload widths
   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 32;
   localparam int INDEX_W = 4;
   localparam int COUNT_W = 5;
   localparam int STAT_W  = 4;

   // queue depths
   localparam int EVQ_DEPTH = 2;
   localparam int RSQ_DEPTH = 4;

   // smallest buffer that can hold a header with one offset
   localparam logic [WORD_W-1:0] MIN_BUFFER = 32'd8;
   localparam logic [WORD_W-1:0] WORD_BYTES = 32'd4;

   // result kinds
   localparam logic KIND_FIELD  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK          = 4'd0;
   localparam logic [STAT_W-1:0] ST_BUF_SHORT   = 4'd1;
   localparam logic [STAT_W-1:0] ST_SIZE_RANGE  = 4'd2;
   localparam logic [STAT_W-1:0] ST_SIZE_SHORT  = 4'd3;
   localparam logic [STAT_W-1:0] ST_FIRST_RANGE = 4'd4;
   localparam logic [STAT_W-1:0] ST_MISALIGNED  = 4'd5;
   localparam logic [STAT_W-1:0] ST_TOO_MANY    = 4'd6;
   localparam logic [STAT_W-1:0] ST_HDR_SIZE    = 4'd7;
   localparam logic [STAT_W-1:0] ST_BAD_OFFSET  = 4'd8;

   // parser phase
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_COLLECT,
      PH_PENDING
   } phase_type;

   // one accepted byte as seen by the back end
   typedef struct packed {
      logic              start;
      logic              word_done;
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] buffer_length;
   } evt_type;

   // one result
   typedef struct packed {
      logic               result_kind;
      logic [INDEX_W-1:0] field_index;
      logic [WORD_W-1:0]  field_offset;
      logic [WORD_W-1:0]  field_length;
      logic [STAT_W-1:0]  status;
      logic [COUNT_W-1:0] num_fields;
      logic               last;
   } rsp_type;

   function automatic rsp_type make_rsp(input logic               kind,
                                        input logic [INDEX_W-1:0] idx,
                                        input logic [WORD_W-1:0]  off,
                                        input logic [WORD_W-1:0]  len,
                                        input logic [STAT_W-1:0]  st,
                                        input logic [COUNT_W-1:0] cnt);
      rsp_type r;
      r.result_kind  = kind;
      r.field_index  = idx;
      r.field_offset = off;
      r.field_length = len;
      r.status       = st;
      r.num_fields   = cnt;
      r.last         = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/othp_front.sv]
// ----------------------------------------------------------------------------
// othp_front: byte intake and word assembly
// Gathers bytes into little-endian 32-bit words and tags each request
// with start and word-complete flags for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module othp_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic [othp_pkg::BYTE_W-1:0]  byte_value,
   input  wire logic [othp_pkg::WORD_W-1:0]  buffer_length,
   input  wire logic                         start_req,
   output othp_pkg::evt_type                 evt
);
   import othp_pkg::*;

   logic [1:0]        biw_ff, biw_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] acc_cur;

   // assemble the current byte into the word
   always_comb begin
      acc_cur = acc_ff | ({{(WORD_W-BYTE_W){1'b0}}, byte_value} << {biw_ff, 3'b000});
      evt.start         = start_req;
      evt.buffer_length = buffer_length;
      evt.word          = acc_cur;
      evt.word_done     = 1'b0;
      biw_in            = biw_ff;
      acc_in            = acc_ff;
      if (accept) begin
         if (start_req) begin
            // a start restarts assembly with this byte as byte 0
            acc_in = {{(WORD_W-BYTE_W){1'b0}}, byte_value};
            biw_in = 2'd1;
         end else if (biw_ff == 2'd3) begin
            evt.word_done = 1'b1;
            acc_in        = '0;
            biw_in        = 2'd0;
         end else begin
            acc_in = acc_cur;
            biw_in = biw_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         biw_ff <= 2'd0;
         acc_ff <= '0;
      end else begin
         biw_ff <= biw_in;
         acc_ff <= acc_in;
      end
   end

endmodule

`default_nettype wire

[rtl/othp_event_queue.sv]
// ----------------------------------------------------------------------------
// othp_event_queue: short queue between front and back end
// Holds assembled byte events so that either side may stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module othp_event_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire othp_pkg::evt_type push_data,
   output logic             full,
   input  wire logic        pop,
   output logic             valid,
   output othp_pkg::evt_type head
);
   import othp_pkg::*;

   localparam int PTR_W = (EVQ_DEPTH > 1) ? $clog2(EVQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(EVQ_DEPTH + 1);

   evt_type             entries_ff [EVQ_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   // status and pointer update
   always_comb begin
      full      = (count_ff == CNT_W'(EVQ_DEPTH));
      valid     = (count_ff != '0);
      head      = entries_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(EVQ_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(EVQ_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/othp_back.sv]
// ----------------------------------------------------------------------------
// othp_back: header checks and descriptor generation
// Keeps the table state, checks each completed word and issues up to two
// results per request.
// ----------------------------------------------------------------------------
`default_nettype none

module othp_back #(
   parameter int MAX_FIELDS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  evt_valid,
   input  wire othp_pkg::evt_type     evt,
   output logic                       evt_take,
   input  wire logic                  room,
   output logic [1:0]                 res_n,
   output othp_pkg::rsp_type [1:0]    res
);
   import othp_pkg::*;

   localparam int CNT_W = $clog2(MAX_FIELDS + 1);
   localparam int WN_W  = CNT_W + 1;

   phase_type          phase_ff, phase_in;
   logic [WN_W-1:0]    wn_ff, wn_in;
   logic [WORD_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [WORD_W-1:0]  prev_ff, prev_in;

   logic [WORD_W-1:0]  word;
   logic [WORD_W-3:0]  cnt_raw;
   logic [WORD_W+1:0]  hdr_bytes;
   logic [1:0]         n;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         wn_ff    <= '0;
         total_ff <= '0;
         count_ff <= '0;
         prev_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         wn_ff    <= wn_in;
         total_ff <= total_in;
         count_ff <= count_in;
         prev_ff  <= prev_in;
      end
   end

   // next state and results
   always_comb begin
      phase_in  = phase_ff;
      wn_in     = wn_ff;
      total_in  = total_ff;
      count_in  = count_ff;
      prev_in   = prev_ff;
      res       = '0;
      n         = 2'd0;
      word      = evt.word;
      cnt_raw   = (WORD_W-2)'((word - WORD_BYTES) >> 2);
      hdr_bytes = (WORD_W+2)'(WORD_BYTES) + {cnt_raw, 2'b00};
      evt_take  = evt_valid && room;

      if (evt_take) begin
         // deferred ok status of the previous table
         if (phase_in == PH_PENDING) begin
            res[n[0]] = make_rsp(KIND_STATUS, '0, '0, '0, ST_OK, COUNT_W'(count_ff));
            n         = n + 2'd1;
            phase_in  = PH_IDLE;
         end

         // start of a new table
         if (evt.start) begin
            phase_in = PH_COLLECT;
            wn_in    = '0;
            total_in = '0;
            count_in = '0;
            prev_in  = '0;
            if (evt.buffer_length < MIN_BUFFER) begin
               res[n[0]] = make_rsp(KIND_STATUS, '0, '0, '0, ST_BUF_SHORT, '0);
               n         = n + 2'd1;
               phase_in  = PH_IDLE;
            end
         end

         // completed header word
         if (phase_in == PH_COLLECT && evt.word_done) begin
            wn_in = wn_ff + WN_W'(1);
            if (wn_ff == '0) begin
               // total size
               total_in = word;
               if (word > evt.buffer_length || word < WORD_BYTES) begin
                  res[n[0]] = make_rsp(KIND_STATUS, '0, '0, '0, ST_SIZE_RANGE, '0);
                  n         = n + 2'd1;
                  phase_in  = PH_IDLE;
               end else if (word == WORD_BYTES) begin
                  res[n[0]] = make_rsp(KIND_STATUS, '0, '0, '0, ST_OK, '0);
                  n         = n + 2'd1;
                  phase_in  = PH_IDLE;
               end else if (word < MIN_BUFFER) begin
                  res[n[0]] = make_rsp(KIND_STATUS, '0, '0, '0, ST_SIZE_SHORT, '0);
                  n         = n + 2'd1;
                  phase_in  = PH_IDLE;
               end
            end else if (wn_ff == WN_W'(1)) begin
               // first offset fixes the field count
               if (word < WORD_BYTES || word > total_ff) begin
                  res[n[0]] = make_rsp(KIND_STATUS, '0, '0, '0, ST_FIRST_RANGE, '0);
                  n         = n + 2'd1;
                  phase_in  = PH_IDLE;
               end else if (word[1:0] != 2'b00) begin
                  res[n[0]] = make_rsp(KIND_STATUS, '0, '0, '0, ST_MISALIGNED, '0);
                  n         = n + 2'd1;
                  phase_in  = PH_IDLE;
               end else if (cnt_raw > (WORD_W-2)'(MAX_FIELDS)) begin
                  res[n[0]] = make_rsp(KIND_STATUS, '0, '0, '0, ST_TOO_MANY, '0);
                  n         = n + 2'd1;
                  phase_in  = PH_IDLE;
               end else if ({2'b00, total_ff} < hdr_bytes) begin
                  res[n[0]] = make_rsp(KIND_STATUS, '0, '0, '0, ST_HDR_SIZE, '0);
                  n         = n + 2'd1;
                  phase_in  = PH_IDLE;
               end else begin
                  count_in = CNT_W'(cnt_raw);
                  prev_in  = word;
                  if (cnt_raw == '0) begin
                     res[n[0]] = make_rsp(KIND_STATUS, '0, '0, '0, ST_OK, '0);
                     n         = n + 2'd1;
                     phase_in  = PH_IDLE;
                  end else if (cnt_raw == (WORD_W-2)'(1)) begin
                     // single field spans to the end of the table
                     res[0]   = make_rsp(KIND_FIELD, '0, word, total_ff - word, ST_OK, '0);
                     res[1]   = make_rsp(KIND_STATUS, '0, '0, '0, ST_OK, COUNT_W'(1));
                     n        = 2'd2;
                     phase_in = PH_IDLE;
                  end
               end
            end else begin
               // later offsets close the previous field
               if (word > total_ff || word < prev_ff) begin
                  res[n[0]] = make_rsp(KIND_STATUS, '0, '0, '0, ST_BAD_OFFSET, '0);
                  n         = n + 2'd1;
                  phase_in  = PH_IDLE;
               end else begin
                  res[0]  = make_rsp(KIND_FIELD, INDEX_W'(wn_ff - WN_W'(2)), prev_ff,
                                     word - prev_ff, ST_OK, '0);
                  n       = 2'd1;
                  prev_in = word;
                  if (wn_ff >= WN_W'(count_ff)) begin
                     // last offset: final field ends at the total size
                     res[1]   = make_rsp(KIND_FIELD, INDEX_W'(count_ff - CNT_W'(1)), word,
                                         total_ff - word, ST_OK, '0);
                     n        = 2'd2;
                     phase_in = PH_PENDING;
                  end
               end
            end
         end

         // mark the final result of this request
         if (n == 2'd1) begin
            res[0].last = 1'b1;
         end else if (n == 2'd2) begin
            res[1].last = 1'b1;
         end
      end
      res_n = n;
   end

endmodule

`default_nettype wire

[rtl/othp_result_queue.sv]
// ----------------------------------------------------------------------------
// othp_result_queue: result buffer towards the consumer
// Takes up to two results a cycle from the back end, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module othp_result_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [1:0]          push_n,
   input  wire othp_pkg::rsp_type [1:0] push_data,
   output logic                     room,
   input  wire logic                pop,
   output logic                     empty,
   output othp_pkg::rsp_type        head
);
   import othp_pkg::*;

   localparam int PTR_W = $clog2(RSQ_DEPTH);
   localparam int CNT_W = $clog2(RSQ_DEPTH + 1);

   rsp_type           entries_ff [RSQ_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_pop;

   // status and pointers; depth is a power of two so pointers wrap freely
   always_comb begin
      empty     = (count_ff == '0);
      room      = (count_ff <= CNT_W'(RSQ_DEPTH - 2));
      head      = entries_ff[rd_ptr_ff];
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(do_pop);
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, two write slots
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push_data[0];
      end
      if (push_n == 2'd2) begin
         entries_ff[wr_ptr_ff + PTR_W'(1)] <= push_data[1];
      end
   end

endmodule

`default_nettype wire

[rtl/offset_table_header_parser.sv]
// ----------------------------------------------------------------------------
// offset_table_header_parser: offset-table header decoder
// Byte-serial decoder for an offset-table header, producing one descriptor
// per field and a closing status.
// ----------------------------------------------------------------------------
// Takes one byte a cycle while full is low: the front end assembles
// little-endian words and passes each request through a two-entry queue to
// the back end, which runs all header checks for a word combinationally and
// writes its results into a four-entry result queue. Results reach the
// rsp_ ports through both registered queues. Most bytes cause no result or
// one; the byte that completes the last offset (or the only offset) causes
// two, and the back end waits while the result queue has fewer than two free
// slots, so sustained intake stays at one byte per cycle as long as results
// are popped as they appear. There is no start-up clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module offset_table_header_parser #(
   parameter int MAX_FIELDS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request side
   input  wire logic                          push,
   output logic                               full,
   input  wire logic [othp_pkg::BYTE_W-1:0]   req_byte_value,
   input  wire logic [othp_pkg::WORD_W-1:0]   req_buffer_length,
   input  wire logic                          req_start_req,
   // result side
   output logic                               empty,
   input  wire logic                          pop,
   output logic                               rsp_result_kind,
   output logic [othp_pkg::INDEX_W-1:0]       rsp_field_index,
   output logic [othp_pkg::WORD_W-1:0]        rsp_field_offset,
   output logic [othp_pkg::WORD_W-1:0]        rsp_field_length,
   output logic [othp_pkg::STAT_W-1:0]        rsp_status,
   output logic [othp_pkg::COUNT_W-1:0]       rsp_num_fields,
   output logic                               rsp_last
);
   import othp_pkg::*;

   evt_type       front_evt;
   evt_type       queue_head;
   logic          queue_valid;
   logic          back_take;
   logic          rsq_room;
   logic [1:0]    back_n;
   rsp_type [1:0] back_res;
   rsp_type       out_head;
   logic          accept;

   assign accept = push && !full;

   // word assembly
   othp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .byte_value    (req_byte_value),
      .buffer_length (req_buffer_length),
      .start_req     (req_start_req),
      .evt           (front_evt)
   );

   // decoupling queue
   othp_event_queue u_evq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_evt),
      .full      (full),
      .pop       (back_take),
      .valid     (queue_valid),
      .head      (queue_head)
   );

   // checks and descriptors
   othp_back #(
      .MAX_FIELDS (MAX_FIELDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .evt_valid (queue_valid),
      .evt       (queue_head),
      .evt_take  (back_take),
      .room      (rsq_room),
      .res_n     (back_n),
      .res       (back_res)
   );

   // result buffer
   othp_result_queue u_rsq (
      .clock     (clock),
      .reset     (reset),
      .push_n    (back_n),
      .push_data (back_res),
      .room      (rsq_room),
      .pop       (pop),
      .empty     (empty),
      .head      (out_head)
   );

   // result ports
   assign rsp_result_kind  = out_head.result_kind;
   assign rsp_field_index  = out_head.field_index;
   assign rsp_field_offset = out_head.field_offset;
   assign rsp_field_length = out_head.field_length;
   assign rsp_status       = out_head.status;
   assign rsp_num_fields   = out_head.num_fields;
   assign rsp_last         = out_head.last;

endmodule

`default_nettype wire
